// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Checks compile away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition a in one cycle implies condition b in the next.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, a, b)

`endif

`endif

// File: src/zof_pkg.sv
package zof_pkg;

  localparam int MaxSamplesDefault = 64;
  localparam int SampleBitsDefault = 16;

  // Commands from the sequencer to the statistics unit.
  typedef struct packed {
    logic add;    // store and accumulate one sample
    logic clear;  // set done, start a new one
    logic mul;    // form n*Q and S*S
    logic thr;    // form threshold 4*(n*Q - S*S)
  } stats_ctl_t;

endpackage

// File: src/zof_sample_ram.sv
module zof_sample_ram #(
  parameter int MAX_SAMPLES = zof_pkg::MaxSamplesDefault,
  parameter int SAMPLE_BITS = zof_pkg::SampleBitsDefault,
  localparam int IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [IdxW-1:0]               waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [IdxW-1:0]               raddr,
  output logic signed [SAMPLE_BITS-1:0] rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low, so a stalled emit keeps its word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/zof_stats.sv
module zof_stats #(
  parameter int MAX_SAMPLES = zof_pkg::MaxSamplesDefault,
  parameter int SAMPLE_BITS = zof_pkg::SampleBitsDefault,
  localparam int CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int LogN  = $clog2(MAX_SAMPLES),
  localparam int SumW  = SAMPLE_BITS + LogN,
  localparam int Sq1W  = 2 * SAMPLE_BITS - 1,
  localparam int QsumW = Sq1W + LogN,
  localparam int NqW   = CntW + QsumW,
  localparam int SsW   = 2 * SumW - 1,
  localparam int RhsW  = NqW + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  zof_pkg::stats_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic [CntW-1:0]               count,
  output logic signed [SumW-1:0]        sum,
  output logic [RhsW-1:0]               rhs
);

  logic [QsumW-1:0]                qsum;
  logic                            sq_pend;
  logic [Sq1W-1:0]                 sq_prod;
  logic signed [2*SAMPLE_BITS-1:0] xx_full;
  logic signed [2*SumW-1:0]        ss_full;
  logic [NqW-1:0]                  nq;
  logic [SsW-1:0]                  ss;

  assign xx_full = x * x;
  assign ss_full = sum * sum;

  // square is registered and folded into the sum of squares in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      qsum    <= '0;
      sq_pend <= 1'b0;
    end else if (ctl.clear) begin
      count   <= '0;
      sum     <= '0;
      qsum    <= '0;
      sq_pend <= 1'b0;
    end else begin
      if (ctl.add) begin
        count <= count + CntW'(1);
        sum   <= sum + SumW'(x);
      end
      if (sq_pend) begin
        qsum <= qsum + QsumW'(sq_prod);
      end
      sq_pend <= ctl.add;
    end
  end

  always_ff @(posedge clk) begin
    sq_prod <= xx_full[Sq1W-1:0];
    if (ctl.mul) begin
      nq <= count * qsum;
      ss <= ss_full[SsW-1:0];
    end
    // n*Q >= S*S always, so the difference stays unsigned
    if (ctl.thr) begin
      rhs <= {nq - NqW'(ss), 2'b00};
    end
  end

endmodule

// File: src/zof_flag_pipe.sv
module zof_flag_pipe #(
  parameter int MAX_SAMPLES = zof_pkg::MaxSamplesDefault,
  parameter int SAMPLE_BITS = zof_pkg::SampleBitsDefault,
  localparam int CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int LogN  = $clog2(MAX_SAMPLES),
  localparam int SumW  = SAMPLE_BITS + LogN,
  localparam int Sq1W  = 2 * SAMPLE_BITS - 1,
  localparam int QsumW = Sq1W + LogN,
  localparam int RhsW  = CntW + QsumW + 2,
  localparam int DW    = SumW + 1,
  localparam int DdW   = 2 * DW - 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_value,
  input  logic                          in_last,
  input  logic [CntW-1:0]               count,
  input  logic signed [SumW-1:0]        sum,
  input  logic [RhsW-1:0]               rhs,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          out_flag,
  output logic                          out_last
);

  logic signed [CntW+SAMPLE_BITS:0] nx;
  logic signed [DW-1:0]             d_next;
  logic signed [2*DW-1:0]           dd_full;

  logic                          va;
  logic signed [DW-1:0]          d;
  logic signed [SAMPLE_BITS-1:0] val_a;
  logic                          last_a;

  logic                          vb;
  logic [DdW-1:0]                dd;
  logic signed [SAMPLE_BITS-1:0] val_b;
  logic                          last_b;

  assign nx      = $signed({1'b0, count}) * in_value;
  assign d_next  = DW'(nx) - DW'(sum);
  assign dd_full = d * d;

  // whole pipe moves as one when the output word is free or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d         <= d_next;
      val_a     <= in_value;
      last_a    <= in_last;
      dd        <= dd_full[DdW-1:0];
      val_b     <= val_a;
      last_b    <= last_a;
      out_value <= val_b;
      out_flag  <= (dd > rhs);
      out_last  <= last_b;
    end
  end

endmodule

// File: src/zscore_outlier_flagger.sv
// Two-sigma outlier flagger. Samples are taken one word per cycle while
// in_stall is low and written to a sample RAM with one write port and one
// read port while count, sum and sum of squares accumulate.
// A set ends on the word with is_last set, or on any word that arrives with
// the buffer already full (that word is dropped). After the SQ, MUL and
// THR states the block replays the set in order, one result word per cycle,
// through a four-stage path (RAM read, n*x - sum, square, compare against
// 4*(n*Q - sum^2)); output stall freezes the whole replay path.
// Input is stalled from the end of a set until its last result word is taken.
`include "assert_macros.svh"

module zscore_outlier_flagger #(
  parameter int MAX_SAMPLES = zof_pkg::MaxSamplesDefault,
  parameter int SAMPLE_BITS = zof_pkg::SampleBitsDefault,
  localparam int IdxW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int LogN  = $clog2(MAX_SAMPLES),
  localparam int SumW  = SAMPLE_BITS + LogN,
  localparam int RhsW  = CntW + 2 * SAMPLE_BITS - 1 + LogN + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_value,
  output logic                          is_anomaly,
  output logic                          last_result
);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_THR  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  zof_pkg::stats_ctl_t           ctl;
  logic [CntW-1:0]               count;
  logic signed [SumW-1:0]        sum;
  logic [RhsW-1:0]               rhs;

  logic                          in_take;
  logic                          full;
  logic                          store;
  logic                          out_take_last;
  logic                          adv;
  logic                          issue;
  logic [CntW-1:0]               rd_idx;
  logic                          rd_valid;
  logic                          rd_last;
  logic signed [SAMPLE_BITS-1:0] rdata;

  assign in_stall      = (state != ST_LOAD);
  assign in_take       = in_valid && !in_stall;
  assign full          = (count == CntW'(MAX_SAMPLES));
  assign store         = in_take && !full;
  assign out_take_last = out_valid && !out_stall && last_result;
  assign adv           = !out_valid || !out_stall;
  assign issue         = (state == ST_EMIT) && adv && (rd_idx != count);

  assign ctl.add   = store;
  assign ctl.clear = out_take_last;
  assign ctl.mul   = (state == ST_MUL);
  assign ctl.thr   = (state == ST_THR);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_take && (full || is_last)) begin
          state_next = ST_SQ;
        end
      end
      // last square lands in the sum of squares during this cycle
      ST_SQ:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_THR;
      ST_THR:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_take_last) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      rd_idx   <= '0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take_last) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + CntW'(1);
      end
      if (adv) begin
        rd_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_last <= (rd_idx == count - CntW'(1));
    end
  end

  zof_sample_ram #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (store),
    .waddr(count[IdxW-1:0]),
    .wdata(sample_value),
    .re   (issue),
    .raddr(rd_idx[IdxW-1:0]),
    .rdata(rdata)
  );

  zof_stats #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_stats (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .x    (sample_value),
    .count(count),
    .sum  (sum),
    .rhs  (rhs)
  );

  zof_flag_pipe #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (rd_valid),
    .in_value (rdata),
    .in_last  (rd_last),
    .count    (count),
    .sum      (sum),
    .rhs      (rhs),
    .out_valid(out_valid),
    .out_value(out_value),
    .out_flag (is_anomaly),
    .out_last (last_result)
  );

  `ASSERT_HOLDS(a_out_only_in_emit, clk, rst, !out_valid || (state == ST_EMIT))
  `ASSERT_HOLDS(a_rd_idx_bound, clk, rst, rd_idx <= count)
  `ASSERT_HOLDS(a_count_bound, clk, rst, count <= CntW'(MAX_SAMPLES))
  `ASSERT_NEXT(a_set_done, clk, rst, out_take_last, (state == ST_LOAD) && (count == '0))

endmodule

// File: bench/tb_top.sv
module tb_top;

  localparam int SW = zof_pkg::SampleBitsDefault;
  localparam int MaxN = zof_pkg::MaxSamplesDefault;
  localparam int RandItems = 12;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 30;
  localparam int CycleLimit = 300000;
  localparam int DirRows = 22;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 flag;
    logic                 last;
  } result_t;

  // pin: the anomaly flag is typed into the row rather than predicted
  typedef struct packed {
    logic signed [SW-1:0] v;
    logic                 last;
    logic                 pin;
    logic                 flag;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] sample_value;
  logic                 is_last;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [SW-1:0] out_value;
  logic                 is_anomaly;
  logic                 last_result;

  zscore_outlier_flagger uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_value(sample_value),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .is_anomaly  (is_anomaly),
    .last_result (last_result)
  );

  // expected output words, oldest first
  result_t pending_words[$];

  // predictor copy of the block state
  logic signed [SW-1:0] held_val  [MaxN];
  logic                 held_pin  [MaxN];
  logic                 held_flag [MaxN];
  int                   n_held;
  longint               sum_acc;
  longint               sq_acc;

  int      err_count;
  int      cycle_count;
  int      burst_left;
  logic    hold_req;
  result_t want_w;

  stim_row_t dir_rows [DirRows] = '{
    // lone samples: zero variance, never flagged
    '{16'sd0,      1'b1, 1'b1, 1'b0},
    '{-16'sd32768, 1'b1, 1'b1, 1'b0},
    '{16'sd32767,  1'b1, 1'b1, 1'b0},
    // two extremes: a pair can never exceed two sigma
    '{-16'sd32768, 1'b0, 1'b1, 1'b0},
    '{16'sd32767,  1'b1, 1'b1, 1'b0},
    // constant set
    '{16'sd32767,  1'b0, 1'b1, 1'b0},
    '{16'sd32767,  1'b0, 1'b1, 1'b0},
    '{16'sd32767,  1'b0, 1'b1, 1'b0},
    '{16'sd32767,  1'b1, 1'b1, 1'b0},
    // nine zeros and one clear outlier
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd0,      1'b0, 1'b1, 1'b0},
    '{16'sd1000,   1'b1, 1'b1, 1'b1},
    // mixed signs, predicted
    '{16'sh1234,   1'b0, 1'b0, 1'b0},
    '{-16'sd22136, 1'b0, 1'b0, 1'b0},
    '{16'sh7ff0,   1'b1, 1'b0, 1'b0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    if (err_count < 40)
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  function automatic void emit_expected();
    longint  n;
    longint  thr;
    longint  d;
    result_t w;
    n = n_held;
    thr = 4 * (n * sq_acc - sum_acc * sum_acc);
    for (int i = 0; i < n_held; i++) begin
      d = n * longint'(held_val[i]) - sum_acc;
      w.value = held_val[i];
      w.flag = held_pin[i] ? held_flag[i] : (d * d > thr);
      w.last = (i == n_held - 1);
      pending_words.push_back(w);
    end
    n_held = 0;
    sum_acc = 0;
    sq_acc = 0;
  endfunction

  function automatic void absorb_sample(input logic signed [SW-1:0] v, input logic last,
                                        input logic pin, input logic pflag);
    // a word arriving on a full buffer is dropped and closes the set
    if (n_held >= MaxN) begin
      emit_expected();
      return;
    end
    held_val[n_held] = v;
    held_pin[n_held] = pin;
    held_flag[n_held] = pflag;
    n_held++;
    sum_acc += longint'(v);
    sq_acc += longint'(v) * longint'(v);
    if (last)
      emit_expected();
  endfunction

  function automatic logic signed [SW-1:0] pick_sample(input logic signed [SW-1:0] base);
    logic signed [SW-1:0] r;
    case ($urandom_range(0, 5))
      0: r = SW'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: r = -16'sd32768;
          1: r = 16'sd32767;
          2: r = 16'sd0;
          default: r = -16'sd1;
        endcase
      end
      2: r = base;
      default: r = base + SW'($urandom_range(0, 64)) - 16'sd32;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic signed [SW-1:0] v, input logic last,
                           input logic pin, input logic pflag);
    in_valid <= 1'b1;
    sample_value <= v;
    is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_sample(v, last, pin, pflag);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // receiver: one long hold-off on request, otherwise changing stall patterns
  initial begin
    int   mode;
    int   mode_left;
    int   hold_cnt;
    logic hold_done;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) @(posedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", out_value, 0);
      end else begin
        want_w = pending_words.pop_front();
        if (out_value !== want_w.value) report("out_value", out_value, want_w.value);
        if (is_anomaly !== want_w.flag) report("is_anomaly", is_anomaly, want_w.flag);
        if (last_result !== want_w.last) report("last_result", last_result, want_w.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[zscore_outlier_flagger] ERROR");
      $finish;
    end
  end

  initial begin
    int                   rand_items;
    int                   sz;
    logic signed [SW-1:0] base;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_value <= '0;
    is_last <= 1'b0;
    hold_req <= 1'b0;
    cycle_count = 0;
    err_count = 0;
    n_held = 0;
    sum_acc = 0;
    sq_acc = 0;
    burst_left = 4;
    rand_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DirRows; r++)
      send_word(dir_rows[r].v, dir_rows[r].last, dir_rows[r].pin, dir_rows[r].flag);

    // full buffer closed by an overflow word, under a long receiver hold-off
    hold_req <= 1'b1;
    base = SW'($urandom);
    for (int i = 0; i < MaxN; i++)
      send_word(pick_sample(base), 1'b0, 1'b0, 1'b0);
    send_word(SW'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0);

    while (rand_items < RandItems) begin
      sz = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      base = SW'($urandom);
      for (int i = 0; i < sz; i++)
        send_word(pick_sample(base), i == sz - 1, 1'b0, 1'b0);
      rand_items += sz;
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("[zscore_outlier_flagger] OK");
    end else begin
      $display("[zscore_outlier_flagger] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/zof_pkg.sv
src/zof_sample_ram.sv
src/zof_stats.sv
src/zof_flag_pipe.sv
src/zscore_outlier_flagger.sv
bench/tb_top.sv
